[hw/rtl/u8vd_pkg.sv]
`timescale 1ns / 1ps

package u8vd_pkg;

	localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
	localparam logic [20:0] MAX_CP         = 21'h10FFFF;
	localparam logic [20:0] SURR_LO        = 21'h00D800;
	localparam logic [20:0] SURR_HI        = 21'h00DFFF;
	localparam logic [20:0] MIN_CP_4       = 21'h010000;
	localparam logic [20:0] MIN_CP_3       = 21'h000800;
	localparam logic [20:0] MIN_CP_2       = 21'h000080;

	localparam logic [2:0] LEN_1 = 3'd1;
	localparam logic [2:0] LEN_2 = 3'd2;
	localparam logic [2:0] LEN_3 = 3'd3;
	localparam logic [2:0] LEN_4 = 3'd4;

	// one input byte's worth of results: cnt replacement transfers, except
	// that slot mid_pos carries the decoded scalar when has_mid is set
	typedef struct packed {
		logic [2:0]  cnt;
		logic        has_mid;
		logic [1:0]  mid_pos;
		logic [20:0] mid_cp;
		logic [2:0]  mid_len;
	} run_desc_t;

endpackage

[hw/rtl/utf8_validating_decoder.sv]
`timescale 1ns / 1ps

// utf8 validating decoder
// input stream: one text byte per transfer in s_axis_tdata[7:0], s_axis_tlast
// marks the final byte of the text (any open sequence is flushed after it)
// output stream: one code point per transfer; tdata holds code_point in
// [20:0] and seq_bytes in [23:21], tuser flags a replacement caused by an
// error, tlast marks the final result released by one input byte
// a byte may release zero to four results; zero bytes end the text and
// release only the flush of an open sequence
// a byte's results pass through the run queue and then the output register
// throughput: one byte per cycle while each byte releases at most one
// result and the output is not stalled; a byte that releases n results
// takes n output transfers, and the run queue (QUEUE_DEPTH entries) lets
// input continue meanwhile until it fills
// the output stage is a register that refills in the same cycle it is taken,
// so output stalls back up only through the run queue to s_axis_tready
// reset clears the open sequence, the queue and the output valid; no
// clearing pass is needed, the block takes input right after reset
module utf8_validating_decoder
	import u8vd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,   // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] seq_bytes
	output logic        m_axis_tuser,   // [0] is_error
	output logic        m_axis_tlast    // last_of_run
);

	run_desc_t   front_desc;
	run_desc_t   head_desc;
	logic        q_empty;
	logic        q_full;
	logic        q_pop;
	logic        in_xfer;
	logic        push;
	logic [20:0] code_point;
	logic [2:0]  seq_bytes;

	assign s_axis_tready = !q_full;
	assign in_xfer       = s_axis_tvalid && !q_full;
	// bytes that release nothing (leads, mid-sequence bytes) skip the queue
	assign push          = in_xfer && (front_desc.cnt != 3'd0);

	// front: classify each byte and keep the open sequence
	u8vd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_xfer),
		.text_byte   (s_axis_tdata),
		.end_of_text (s_axis_tlast),
		.desc        (front_desc)
	);

	// short queue of per-byte result runs
	u8vd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (front_desc),
		.pop       (q_pop),
		.head      (head_desc),
		.empty     (q_empty),
		.full      (q_full)
	);

	// back: expand each run into output transfers
	u8vd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_desc),
		.empty       (q_empty),
		.pop         (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.code_point  (code_point),
		.is_error    (m_axis_tuser),
		.seq_bytes   (seq_bytes),
		.last_of_run (m_axis_tlast)
	);

	assign m_axis_tdata = {seq_bytes, code_point};

endmodule

[hw/rtl/u8vd_front.sv]
`timescale 1ns / 1ps

module u8vd_front
	import u8vd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  logic [7:0] text_byte,
	input  logic      end_of_text,
	output run_desc_t desc
);

	logic [1:0]  pend_q;
	logic [2:0]  exp_q;
	logic [20:0] part_q;

	logic [1:0]  pend_d;
	logic [2:0]  exp_d;
	logic [20:0] part_d;

	logic        is_cont;
	logic [2:0]  have;
	logic [20:0] part_new;
	logic        val_ok;

	assign is_cont  = (text_byte[7:6] == 2'b10);
	assign have     = {1'b0, pend_q} + 3'd1;
	assign part_new = {part_q[14:0], text_byte[5:0]};

	always_comb begin
		case (exp_q)
			LEN_2: val_ok = (part_new >= MIN_CP_2);
			LEN_3: val_ok = (part_new >= MIN_CP_3) &&
				!((part_new >= SURR_LO) && (part_new <= SURR_HI));
			LEN_4: val_ok = (part_new >= MIN_CP_4) && (part_new <= MAX_CP);
			default: val_ok = 1'b0;
		endcase
	end

	always_comb begin
		pend_d = pend_q;
		exp_d  = exp_q;
		part_d = part_q;
		desc   = '0;
		desc.mid_cp  = {13'd0, text_byte};
		desc.mid_len = LEN_1;

		if (text_byte == 8'd0) begin
			// terminator: flush what is held, nothing of its own
			desc.cnt = {1'b0, pend_q};
			pend_d = '0;
			exp_d  = '0;
			part_d = '0;
		end else if ((pend_q != 2'd0) && is_cont) begin
			if (have >= exp_q) begin
				if (val_ok) begin
					desc.cnt     = 3'd1;
					desc.has_mid = 1'b1;
					desc.mid_pos = 2'd0;
					desc.mid_cp  = part_new;
					desc.mid_len = exp_q;
				end else begin
					desc.cnt = have;
				end
				pend_d = '0;
				exp_d  = '0;
				part_d = '0;
			end else begin
				pend_d = have[1:0];
				part_d = part_new;
			end
		end else begin
			// broken or no open sequence: flush, then decode as a lead
			pend_d = '0;
			exp_d  = '0;
			part_d = '0;
			desc.mid_pos = pend_q;
			if (!text_byte[7]) begin
				desc.cnt     = {1'b0, pend_q} + 3'd1;
				desc.has_mid = 1'b1;
			end else if (text_byte[7:5] == 3'b110) begin
				desc.cnt = {1'b0, pend_q};
				pend_d = 2'd1;
				exp_d  = LEN_2;
				part_d = {16'd0, text_byte[4:0]};
			end else if (text_byte[7:4] == 4'b1110) begin
				desc.cnt = {1'b0, pend_q};
				pend_d = 2'd1;
				exp_d  = LEN_3;
				part_d = {17'd0, text_byte[3:0]};
			end else if (text_byte[7:3] == 5'b11110) begin
				desc.cnt = {1'b0, pend_q};
				pend_d = 2'd1;
				exp_d  = LEN_4;
				part_d = {18'd0, text_byte[2:0]};
			end else begin
				desc.cnt = {1'b0, pend_q} + 3'd1;
			end
		end

		// end of text flushes whatever is still open, after the byte itself
		if (end_of_text && (pend_d != 2'd0)) begin
			desc.cnt = desc.cnt + {1'b0, pend_d};
			pend_d = '0;
			exp_d  = '0;
			part_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			exp_q  <= '0;
			part_q <= '0;
		end else if (accept) begin
			pend_q <= pend_d;
			exp_q  <= exp_d;
			part_q <= part_d;
		end
	end

endmodule

[hw/rtl/u8vd_queue.sv]
`timescale 1ns / 1ps

module u8vd_queue
	import u8vd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  run_desc_t push_desc,
	input  logic      pop,
	output run_desc_t head,
	output logic      empty,
	output logic      full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	run_desc_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign empty   = (count_q == CNT_W'(0));
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[hw/rtl/u8vd_back.sv]
`timescale 1ns / 1ps

module u8vd_back
	import u8vd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  run_desc_t   head,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [20:0] code_point,
	output logic        is_error,
	output logic [2:0]  seq_bytes,
	output logic        last_of_run
);

	logic [1:0]  idx_q;
	logic        valid_q;
	logic [20:0] cp_q;
	logic        err_q;
	logic [2:0]  len_q;
	logic        last_q;

	logic advance;
	logic load;
	logic is_mid;
	logic is_last;

	assign advance = !valid_q || out_ready;
	assign load    = advance && !empty;
	assign is_mid  = head.has_mid && (head.mid_pos == idx_q);
	assign is_last = ({1'b0, idx_q} + 3'd1) == head.cnt;
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= !empty;
			if (load) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q   <= is_mid ? head.mid_cp : REPLACEMENT_CP;
			err_q  <= !is_mid;
			len_q  <= is_mid ? head.mid_len : LEN_1;
			last_q <= is_last;
		end
	end

	assign out_valid   = valid_q;
	assign code_point  = cp_q;
	assign is_error    = err_q;
	assign seq_bytes   = len_q;
	assign last_of_run = last_q;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
	import u8vd_pkg::*;

	// one decoded scalar as it leaves the block
	typedef struct packed {
		logic [20:0] code_point;
		logic        is_error;
		logic [2:0]  seq_bytes;
		logic        last_of_run;
	} scalar_t;

	// tracks the open sequence and the scalars still owed by the block
	class decode_scoreboard;
		logic [1:0]  held;      // bytes of the open sequence, 0 = none open
		logic [2:0]  seq_len;   // length announced by the lead byte
		logic [20:0] acc;       // payload bits gathered so far
		scalar_t     awaited[$];
		int unsigned mismatches;

		function new();
			held = '0;
			seq_len = '0;
			acc = '0;
			mismatches = 0;
		endfunction

		function void owe(logic [20:0] cp, logic err, logic [2:0] len);
			scalar_t s;
			s.code_point = cp;
			s.is_error = err;
			s.seq_bytes = len;
			s.last_of_run = 1'b0;
			awaited.push_back(s);
		endfunction

		// every held byte comes back as its own replacement
		function void drop_open(logic [2:0] count);
			for (int i = 0; i < count; i++)
				owe(REPLACEMENT_CP, 1'b1, LEN_1);
			held = '0;
			seq_len = '0;
			acc = '0;
		endfunction

		function bit legal_scalar(logic [2:0] len, logic [20:0] cp);
			case (len)
				LEN_2: return cp >= MIN_CP_2;
				LEN_3: return cp >= MIN_CP_3 && !(cp >= SURR_LO && cp <= SURR_HI);
				LEN_4: return cp >= MIN_CP_4 && cp <= MAX_CP;
				default: return 1'b0;
			endcase
		endfunction

		function void open_with(logic [7:0] b);
			if (b < 8'h80) begin
				owe({13'd0, b}, 1'b0, LEN_1);
			end else if (b[7:5] == 3'b110) begin
				seq_len = LEN_2;
				acc = {16'd0, b[4:0]};
				held = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				seq_len = LEN_3;
				acc = {17'd0, b[3:0]};
				held = 2'd1;
			end else if (b[7:3] == 5'b11110) begin
				seq_len = LEN_4;
				acc = {18'd0, b[2:0]};
				held = 2'd1;
			end else begin
				owe(REPLACEMENT_CP, 1'b1, LEN_1);
			end
		endfunction

		// works out every scalar released by one accepted byte
		function void note_byte(logic [7:0] b, logic eot);
			int unsigned before_cnt;
			logic [2:0]  have;
			scalar_t     tail;
			before_cnt = awaited.size();
			if (b == 8'h00) begin
				drop_open({1'b0, held});
			end else if (held != 2'd0 && b[7:6] == 2'b10) begin
				have = {1'b0, held} + 3'd1;
				acc = {acc[14:0], b[5:0]};
				if (have >= seq_len) begin
					if (legal_scalar(seq_len, acc)) begin
						owe(acc, 1'b0, seq_len);
						held = '0;
						seq_len = '0;
						acc = '0;
					end else begin
						drop_open(have);
					end
				end else begin
					held = have[1:0];
				end
			end else begin
				drop_open({1'b0, held});
				open_with(b);
			end
			if (eot && held != 2'd0)
				drop_open({1'b0, held});
			if (awaited.size() > before_cnt) begin
				tail = awaited.pop_back();
				tail.last_of_run = 1'b1;
				awaited.push_back(tail);
			end
		endfunction

		function void check_result(scalar_t got);
			scalar_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result cp=%h err=%b len=%0d last=%b",
						got.code_point, got.is_error, got.seq_bytes, got.last_of_run);
				return;
			end
			want = awaited.pop_front();
			if (got.code_point !== want.code_point || got.is_error !== want.is_error ||
					got.seq_bytes !== want.seq_bytes || got.last_of_run !== want.last_of_run) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected cp=%h err=%b len=%0d last=%b, got cp=%h err=%b len=%0d last=%b",
						want.code_point, want.is_error, want.seq_bytes, want.last_of_run,
						got.code_point, got.is_error, got.seq_bytes, got.last_of_run);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	decode_scoreboard sb;
	bit               steady = 1'b0;   // no idling on either side while set
	int unsigned      bytes_sent = 0;

	utf8_validating_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit idle_now();
		return !steady && ($urandom_range(0, 99) < 21);
	endfunction

	always @(negedge clk) begin
		m_axis_tready <= !idle_now();
	end

	always @(posedge clk) begin
		scalar_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.code_point = m_axis_tdata[20:0];
			got.seq_bytes = m_axis_tdata[23:21];
			got.is_error = m_axis_tuser;
			got.last_of_run = m_axis_tlast;
			sb.check_result(got);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eot);
		@(negedge clk);
		while (idle_now()) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eot;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_byte(b, eot);
		bytes_sent++;
	endtask

	// encodes cp in len bytes and sends the first keep of them
	task automatic send_encoded(input logic [20:0] cp, input int len, input int keep,
			input logic eot);
		logic [7:0] seq [4];
		case (len)
			2: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++)
			send_byte(seq[i], eot && i == keep - 1);
	endtask

	initial begin
		int unsigned pick;
		int unsigned len;
		logic [20:0] cp;
		logic        eot;

		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed opening
		send_byte(8'h01, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_encoded(21'h0000A9, 2, 2, 1'b0);
		send_encoded(SURR_LO, 3, 3, 1'b0);          // surrogate
		send_encoded(21'h000000, 2, 2, 1'b0);       // overlong two-byte form
		send_encoded(21'h110000, 4, 4, 1'b0);       // above the last scalar
		send_encoded(MAX_CP, 4, 4, 1'b0);
		send_byte(8'h80, 1'b0);                     // lone continuation
		send_byte(8'hFF, 1'b0);
		send_byte(8'hF8, 1'b0);
		send_encoded(21'h0020AC, 3, 1, 1'b0);       // lead cut off by ascii
		send_byte(8'h41, 1'b0);
		send_encoded(MIN_CP_4, 4, 2, 1'b0);         // open sequence hit by terminator
		send_byte(8'h00, 1'b0);
		send_encoded(21'h0020AC, 3, 2, 1'b1);       // end of text mid sequence

		// random part: mostly well formed sequences, some broken ones and noise
		while (bytes_sent < 360) begin
			steady = bytes_sent >= 150 && bytes_sent < 230;
			pick = $urandom_range(0, 99);
			eot = $urandom_range(0, 99) < 4;
			if (pick < 20) begin
				send_byte(8'($urandom_range(1, 127)), eot);
			end else if (pick < 35) begin
				if ($urandom_range(0, 9) == 0)
					cp = 21'($urandom_range(0, 'h7F));
				else
					cp = 21'($urandom_range('h80, 'h7FF));
				send_encoded(cp, 2, 2, eot);
			end else if (pick < 55) begin
				len = $urandom_range(0, 9);
				if (len == 0)
					cp = 21'($urandom_range('hD800, 'hDFFF));
				else if (len == 1)
					cp = 21'($urandom_range(0, 'h7FF));
				else begin
					cp = 21'($urandom_range('h800, 'hFFFF));
					if (cp >= SURR_LO && cp <= SURR_HI)
						cp = cp ^ 21'h002000;
				end
				send_encoded(cp, 3, 3, eot);
			end else if (pick < 72) begin
				len = $urandom_range(0, 9);
				if (len == 0)
					cp = 21'($urandom_range('h110000, 'h1FFFFF));
				else if (len == 1)
					cp = 21'($urandom_range(0, 'hFFFF));
				else
					cp = 21'($urandom_range('h10000, 'h10FFFF));
				send_encoded(cp, 4, 4, eot);
			end else if (pick < 82) begin
				// truncated sequence, the next byte or end of text breaks it
				len = $urandom_range(2, 4);
				cp = 21'($urandom_range('h80, 'h10FFFF));
				send_encoded(cp, len, $urandom_range(1, len - 1), eot);
			end else if (pick < 92) begin
				send_byte(8'($urandom_range(0, 255)), eot);
			end else if (pick < 96) begin
				send_byte(8'h00, eot);
			end else begin
				send_byte(8'($urandom_range('h80, 'hBF)), eot);
			end
		end
		steady = 1'b0;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// drain the owed scalars, then keep watching for anything stray
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
			$display("utf8_validating_decoder test passed");
		end else begin
			$display("utf8_validating_decoder test failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("utf8_validating_decoder test failed");
		$finish;
	end

endmodule
